FILE: src/knnpc_pkg.sv
// shared constants, codes and types for the knn point classifier
`timescale 1ns / 1ps
`default_nettype none
package knnpc_pkg;

  localparam int MaxPoints = 1024;
  localparam int MinPoints = 10;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = $clog2(MaxPoints + 1);
  localparam int CoordW    = 16;
  localparam int LabelW    = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int SqW       = 2 * DiffW;
  localparam int DistW     = SqW + 1;
  localparam int StatusW   = 3;
  localparam int ActionW   = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_NEW    = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_BAD_K = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_FEW   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_APPEND,
    S_SEL_RD,
    S_SEL_D1,
    S_SEL_D2,
    S_SEL_CMP,
    S_SEL_END,
    S_V_RDI,
    S_V_LATI,
    S_V_RDJ,
    S_V_CMPJ,
    S_V_UPD,
    S_DONE
  } state_t;

  // ordering key of a stored point during neighbor selection
  typedef struct packed {
    logic [DistW-1:0]         sqd;
    logic signed [LabelW-1:0] lab;
    logic [AddrW-1:0]         idx;
  } nkey_t;

endpackage
`default_nettype wire

FILE: src/knnpc_dist.sv
// two-stage squared euclidean distance unit
`timescale 1ns / 1ps
`default_nettype none
module knnpc_dist
  import knnpc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [CoordW-1:0] ax,
  input  wire logic signed [CoordW-1:0] ay,
  input  wire logic signed [CoordW-1:0] bx,
  input  wire logic signed [CoordW-1:0] by,
  output logic             [DistW-1:0]  sq_dist
);

  logic signed [DiffW-1:0] dx_r, dy_r;
  logic signed [SqW-1:0]   sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    dx_r  <= DiffW'(ax) - DiffW'(bx);
    dy_r  <= DiffW'(ay) - DiffW'(by);
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
  end

  assign sq_dist = DistW'(unsigned'(sqx_r)) + DistW'(unsigned'(sqy_r));

endmodule
`default_nettype wire

FILE: src/knn_point_classifier.sv
// knn point classifier: store of labeled points, load and query sequencer
//
// one input channel (in_*) carries requests: tuser is the action, tdata the
// label, point and k. every request gives exactly one result on out_*.
// a new-set load replaces the store with its one point. an append scans the
// store for a duplicate, one stored point at a time. a query first scans
// the store for an exact match and returns its label; otherwise it runs k
// selection passes through the shared distance unit, then a vote.
// the store is one memory with one write port and one read port, and the
// distance unit is shared by all passes.
// in_tready is high only while the sequencer is idle; one request is
// worked at a time. the result sits in an output register, so a new
// request is taken while it waits; a later result holds in the sequencer
// until the receiver takes the earlier one.
// reset empties the store (count zero) and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module knn_point_classifier
  import knnpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // point_label, coord_x, coord_y, neighbor_count
  input  wire logic [1:0]  in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // result_label, status
);

  logic [CoordW*2+LabelW-1:0] store_mem [MaxPoints];
  logic [LabelW-1:0]          near_mem  [MaxPoints];
  logic [CoordW*2+LabelW-1:0] rdata_r;
  logic [LabelW-1:0]          nrdata_r;

  state_t state_r, state_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;
  logic [CountW-1:0] step_r, step_nxt;
  logic [CountW-1:0] k_r, k_nxt;
  logic [CountW-1:0] votes_r, votes_nxt;
  logic [CountW-1:0] bvotes_r, bvotes_nxt;
  logic              query_r, query_nxt;
  logic              bvalid_r, bvalid_nxt;
  logic signed [CoordW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [LabelW-1:0] qlab_r, qlab_nxt;
  logic signed [LabelW-1:0] vlab_r, vlab_nxt;
  logic signed [LabelW-1:0] res_r, res_nxt;
  status_t st_r, st_nxt;
  nkey_t best_r, best_nxt, prev_r, prev_nxt, cand;
  logic out_valid_r, out_valid_nxt;
  logic [LabelW-1:0] out_lab_r, out_lab_nxt;
  status_t out_st_r, out_st_nxt;

  logic                       we;
  logic [AddrW-1:0]           waddr;
  logic [CoordW*2+LabelW-1:0] wdata;
  logic                       nwe;
  logic [AddrW-1:0]           naddr;

  logic signed [CoordW-1:0] r_x, r_y;
  logic signed [LabelW-1:0] r_lab;
  logic [DistW-1:0]         sq_dist;
  logic                     accept;
  action_t                  in_act;

  assign r_lab  = rdata_r[LabelW-1:0];
  assign r_x    = rdata_r[LabelW +: CoordW];
  assign r_y    = rdata_r[LabelW+CoordW +: CoordW];
  assign accept = in_tvalid && in_tready;
  assign in_act = action_t'(in_tuser);

  function automatic logic key_lt(nkey_t a, nkey_t b);
    logic lt;
    lt = (a.sqd < b.sqd) ||
         (a.sqd == b.sqd && a.lab < b.lab) ||
         (a.sqd == b.sqd && a.lab == b.lab && a.idx < b.idx);
    return lt;
  endfunction

  knnpc_dist u_dist (
    .clk     (clk),
    .ax      (r_x),
    .ay      (r_y),
    .bx      (qx_r),
    .by      (qy_r),
    .sq_dist (sq_dist)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    rdata_r <= store_mem[idx_r[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nwe) begin
      near_mem[naddr] <= best_r.lab;
    end
    nrdata_r <= near_mem[naddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
    k_r      <= k_nxt;
    votes_r  <= votes_nxt;
    bvotes_r <= bvotes_nxt;
    query_r  <= query_nxt;
    bvalid_r <= bvalid_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    qlab_r   <= qlab_nxt;
    vlab_r   <= vlab_nxt;
    res_r    <= res_nxt;
    st_r     <= st_nxt;
    best_r   <= best_nxt;
    prev_r   <= prev_nxt;
    out_lab_r <= out_lab_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign cand = '{sqd: sq_dist, lab: r_lab, idx: idx_r[AddrW-1:0]};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    votes_nxt     = votes_r;
    bvotes_nxt    = bvotes_r;
    query_nxt     = query_r;
    bvalid_nxt    = bvalid_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qlab_nxt      = qlab_r;
    vlab_nxt      = vlab_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    best_nxt      = best_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_lab_nxt   = out_lab_r;
    out_st_nxt    = out_st_r;
    in_tready     = 1'b0;
    we            = 1'b0;
    waddr         = count_r[AddrW-1:0];
    wdata         = {qy_r, qx_r, qlab_r};
    nwe           = 1'b0;
    naddr         = idx_r[AddrW-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          qlab_nxt  = in_tdata[15:0];
          qx_nxt    = in_tdata[31:16];
          qy_nxt    = in_tdata[47:32];
          k_nxt     = in_tdata[58:48];
          query_nxt = (in_act == ACT_QUERY);
          res_nxt   = '0;
          st_nxt    = ST_OK;
          idx_nxt   = '0;
          state_nxt = S_DONE;
          unique case (in_act)
            ACT_NEW: begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = in_tdata[47:0];
              count_nxt = CountW'(1);
            end
            ACT_APPEND: begin
              if (count_r == CountW'(MaxPoints)) begin
                st_nxt = ST_FULL;
              end else begin
                state_nxt = S_FIND_RD;
              end
            end
            ACT_QUERY: begin
              if (in_tdata[58:48] == '0 || in_tdata[58:48] > count_r) begin
                st_nxt = ST_BAD_K;
              end else if (count_r < CountW'(MinPoints)) begin
                st_nxt = ST_FEW;
              end else begin
                state_nxt = S_FIND_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIND_RD: begin
        if (idx_r == count_r) begin
          if (query_r) begin
            idx_nxt    = '0;
            step_nxt   = '0;
            bvalid_nxt = 1'b0;
            state_nxt  = S_SEL_RD;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          state_nxt = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (r_x == qx_r && r_y == qy_r) begin
          if (query_r) begin
            res_nxt = r_lab;
          end else begin
            st_nxt = ST_DUP;
          end
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end
      S_APPEND: begin
        we        = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_SEL_RD: begin
        state_nxt = (idx_r == count_r) ? S_SEL_END : S_SEL_D1;
      end
      S_SEL_D1: state_nxt = S_SEL_D2;
      S_SEL_D2: state_nxt = S_SEL_CMP;
      S_SEL_CMP: begin
        // next pick is the least key above the previous pick
        if ((step_r == '0 || key_lt(prev_r, cand)) &&
            (!bvalid_r || key_lt(cand, best_r))) begin
          best_nxt   = cand;
          bvalid_nxt = 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SEL_RD;
      end
      S_SEL_END: begin
        nwe        = 1'b1;
        naddr      = step_r[AddrW-1:0];
        prev_nxt   = best_r;
        bvalid_nxt = 1'b0;
        idx_nxt    = '0;
        if (step_r + 1'b1 == k_r) begin
          step_nxt   = '0;
          bvotes_nxt = '0;
          res_nxt    = '0;
          state_nxt  = S_V_RDI;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_SEL_RD;
        end
      end
      S_V_RDI: begin
        naddr = step_r[AddrW-1:0];
        state_nxt = (step_r == k_r) ? S_DONE : S_V_LATI;
      end
      S_V_LATI: begin
        vlab_nxt  = nrdata_r;
        idx_nxt   = '0;
        votes_nxt = '0;
        state_nxt = S_V_RDJ;
      end
      S_V_RDJ: begin
        state_nxt = (idx_r == k_r) ? S_V_UPD : S_V_CMPJ;
      end
      S_V_CMPJ: begin
        if (nrdata_r == vlab_r) begin
          votes_nxt = votes_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_V_RDJ;
      end
      S_V_UPD: begin
        if (votes_r > bvotes_r || (votes_r == bvotes_r && vlab_r < res_r)) begin
          bvotes_nxt = votes_r;
          res_nxt    = vlab_r;
        end
        step_nxt  = step_r + 1'b1;
        state_nxt = S_V_RDI;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_lab_nxt   = (st_r == ST_OK) ? res_r : '0;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_st_r, out_lab_r};

endmodule
`default_nettype wire

FILE: src/knnpc_checker.sv
// port-level checks for the knn point classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module knnpc_checker
  import knnpc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // every request leaves the idle state, so no two are taken back to back
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18:16] != ST_OK |-> out_tdata[15:0] == '0)
    else $error("failed result carries a label");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:16] <= ST_FEW)
    else $error("status code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind knn_point_classifier knnpc_checker u_knnpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
